[design/tms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, key codes, tempo values and the melody table of the
// tempo melody sequencer.
// ----------------------------------------------------------------------------
package tms_pkg;

  // Input transaction: one pass of the control loop.
  typedef struct packed {
    logic [7:0] key;
    logic       tick;
  } in_item_t;

  // Result transaction: buzzer, LEDs, screen and position.
  typedef struct packed {
    logic        buzzer_enable;
    logic [10:0] buzzer_freq;
    logic        led_one;
    logic        led_two;
    logic [2:0]  screen_code;
    logic [5:0]  note_position;
  } out_item_t;

  // One melody table entry.
  typedef struct packed {
    logic [10:0] pitch;
    logic [3:0]  length;
  } melody_word_t;

  // Configuration register indexes, widths and reset values.
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic CFG_COUNT_STEP = 1'b0;
  localparam logic CFG_GO_STEP    = 1'b1;
  localparam logic [7:0] COUNT_STEP_RESET = 8'd100;
  localparam logic [7:0] GO_STEP_RESET    = 8'd200;

  // Melody layout.
  localparam int unsigned FIRST_SONG_NOTES  = 57;
  localparam int unsigned SECOND_SONG_NOTES = 25;
  localparam int unsigned ROM_DEPTH   = FIRST_SONG_NOTES + SECOND_SONG_NOTES;
  localparam int unsigned ROM_ADDR_W  = 7;
  localparam logic [ROM_ADDR_W-1:0] SECOND_BASE = ROM_ADDR_W'(FIRST_SONG_NOTES);

  // Elapsed tick counter saturation.
  localparam logic [8:0] ELAPSED_MAX = 9'd511;

  // Key codes.
  localparam logic [7:0] KEY_STAR  = 8'h2A;
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_ONE   = 8'h31;
  localparam logic [7:0] KEY_TWO   = 8'h32;
  localparam logic [7:0] KEY_THREE = 8'h33;
  localparam logic [7:0] KEY_FOUR  = 8'h34;
  localparam logic [7:0] KEY_FIVE  = 8'h35;
  localparam logic [7:0] KEY_SIX   = 8'h36;
  localparam logic [7:0] KEY_SEVEN = 8'h37;
  localparam logic [7:0] KEY_PAUSE = 8'h38;
  localparam logic [7:0] KEY_RESUME = 8'h39;

  // Tempo units selected by the tempo keys.
  localparam logic [5:0] TEMPO_20 = 6'd20;
  localparam logic [5:0] TEMPO_25 = 6'd25;
  localparam logic [5:0] TEMPO_30 = 6'd30;
  localparam logic [5:0] TEMPO_35 = 6'd35;
  localparam logic [5:0] TEMPO_40 = 6'd40;

  // Song selection codes.
  localparam logic [1:0] SONG_NONE   = 2'd0;
  localparam logic [1:0] SONG_FIRST  = 2'd1;
  localparam logic [1:0] SONG_SECOND = 2'd2;

  // Screen codes.
  localparam logic [2:0] SCR_WELCOME = 3'd0;
  localparam logic [2:0] SCR_LIST    = 3'd1;
  localparam logic [2:0] SCR_THREE   = 3'd2;
  localparam logic [2:0] SCR_TWO     = 3'd3;
  localparam logic [2:0] SCR_ONE     = 3'd4;
  localparam logic [2:0] SCR_GO      = 3'd5;
  localparam logic [2:0] SCR_BLANK   = 3'd6;

  // LED bit masks.
  localparam logic [1:0] LED_ONE_BIT = 2'b01;
  localparam logic [1:0] LED_TWO_BIT = 2'b10;

  localparam logic [10:0] ROM_PITCH [0:ROM_DEPTH-1] = '{
    11'd523, 11'd587, 11'd622, 11'd587, 11'd523, 11'd0, 11'd523, 11'd622,
    11'd523, 11'd622, 11'd0, 11'd523, 11'd622, 11'd587, 11'd523, 11'd0,
    11'd523, 11'd523, 11'd523, 11'd622, 11'd523, 11'd622, 11'd0, 11'd466,
    11'd587, 11'd523, 11'd466, 11'd0, 11'd784, 11'd494, 11'd784, 11'd494,
    11'd0, 11'd784, 11'd880, 11'd0, 11'd932, 11'd1397, 11'd880, 11'd784,
    11'd0, 11'd784, 11'd784, 11'd784, 11'd880, 11'd880, 11'd880, 11'd932,
    11'd1397, 11'd880, 11'd784, 11'd0, 11'd698, 11'd784, 11'd932, 11'd784,
    11'd698,
    11'd349, 11'd349, 11'd392, 11'd329, 11'd494, 11'd440, 11'd349, 11'd349,
    11'd392, 11'd349, 11'd523, 11'd494, 11'd349, 11'd349, 11'd659, 11'd587,
    11'd494, 11'd466, 11'd392, 11'd659, 11'd659, 11'd587, 11'd494, 11'd523,
    11'd494
  };

  localparam logic [3:0] ROM_LENGTH [0:ROM_DEPTH-1] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd8, 4'd2, 4'd1, 4'd1,
    4'd3, 4'd1, 4'd4, 4'd4, 4'd4, 4'd8, 4'd3, 4'd1, 4'd4, 4'd4,
    4'd4, 4'd8, 4'd3, 4'd1, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3,
    4'd1, 4'd4, 4'd4, 4'd4, 4'd8
  };

  // Table look-up; addresses past the end read as a silent zero-length note.
  function automatic melody_word_t rom_read(input logic [ROM_ADDR_W-1:0] addr);
    melody_word_t w;
    w = '0;
    if (addr < ROM_ADDR_W'(ROM_DEPTH)) begin
      w.pitch  = ROM_PITCH[addr];
      w.length = ROM_LENGTH[addr];
    end
    return w;
  endfunction

endpackage

[design/tms_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/tempo_melody_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_melody_sequencer_core
// Keypad driven music box controller: welcome, song list, countdown and
// note playback, one control pass per input transaction.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                    Handshake
//  in_ch     sink       key, tick                                  valid/ready
//  out_ch    source     buzzer, freq, LEDs, screen, note position  valid/ready
//  cfg_*     sink       index 0 count step, 1 go step (8 bit)      write enable
//
//  One transaction is accepted per cycle whenever the output register is
//  empty or being drained; its result appears in the output register on the
//  next cycle. The whole pass, including the melody table look-up and the
//  note length times tempo product, is combinational. Synchronous active-low
//  reset restores control state, configuration and output valid, not output data.
// ----------------------------------------------------------------------------
module tempo_melody_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  tms_stream_if.sink                      in_ch,
  tms_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Top phase codes.
  localparam logic [2:0] TOP_WELCOME = 3'd0;
  localparam logic [2:0] TOP_LIST    = 3'd1;
  localparam logic [2:0] TOP_COUNT   = 3'd2;
  localparam logic [2:0] TOP_PLAY    = 3'd3;
  localparam logic [2:0] TOP_WAIT    = 3'd4;

  // Countdown phase codes.
  localparam logic [2:0] CNT_IDLE  = 3'd0;
  localparam logic [2:0] CNT_THREE = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_ONE   = 3'd3;
  localparam logic [2:0] CNT_GO    = 3'd4;
  localparam logic [2:0] CNT_DONE  = 3'd5;

  // Note phase codes.
  localparam logic [1:0] NOTE_IDLE  = 2'd0;
  localparam logic [1:0] NOTE_START = 2'd1;
  localparam logic [1:0] NOTE_SOUND = 2'd2;

  logic [7:0]  count_step_r, go_step_r;
  logic [2:0]  top_r, top_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  note_r, note_nxt;
  logic [1:0]  song_r, song_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [5:0]  tempo_r, tempo_nxt;
  logic [8:0]  elapsed_r, elapsed_nxt;
  logic [10:0] pitch_r, pitch_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [1:0]  led_r, led_nxt;

  logic                         out_valid_r;
  tms_pkg::out_item_t           out_data_r, out_data_nxt;
  logic                         in_acc;
  logic                         sounding;
  logic [2:0]                   screen;
  logic [5:0]                   song_notes;
  logic [tms_pkg::ROM_ADDR_W-1:0] rom_addr;
  tms_pkg::melody_word_t        rom_word;
  logic [9:0]                   note_limit;
  logic [7:0]                   key;

  assign key    = in_ch.data.key;
  assign in_acc = in_ch.valid && in_ch.ready;

  // The output register parts the two sides: take input when it frees up.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Melody length of the chosen song.
  always_comb begin
    case (song_r)
      tms_pkg::SONG_FIRST:  song_notes = 6'(tms_pkg::FIRST_SONG_NOTES);
      tms_pkg::SONG_SECOND: song_notes = 6'(tms_pkg::SECOND_SONG_NOTES);
      default:              song_notes = 6'd0;
    endcase
  end

  // Table address and note duration limit.
  assign rom_addr   = ((song_r == tms_pkg::SONG_SECOND) ? tms_pkg::SECOND_BASE
                                                       : '0) + {1'b0, idx_r};
  assign rom_word   = tms_pkg::rom_read(rom_addr);
  assign note_limit = {6'd0, len_r} * {4'd0, tempo_r};

  // One control pass: tick, top step, countdown step, note step, keys, screen and output.
  always_comb begin
    top_nxt     = top_r;
    cnt_nxt     = cnt_r;
    note_nxt    = note_r;
    song_nxt    = song_r;
    idx_nxt     = idx_r;
    tempo_nxt   = tempo_r;
    elapsed_nxt = elapsed_r;
    pitch_nxt   = pitch_r;
    len_nxt     = len_r;
    led_nxt     = led_r;
    sounding    = 1'b0;

    if (in_ch.data.tick && elapsed_r != tms_pkg::ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + 9'd1;
    end

    unique case (top_r)
      TOP_WELCOME: begin
        idx_nxt  = '0;
        song_nxt = tms_pkg::SONG_NONE;
        if (key == tms_pkg::KEY_STAR) begin
          top_nxt = TOP_LIST;
          led_nxt = led_nxt | tms_pkg::LED_ONE_BIT;
        end
      end
      TOP_LIST: begin
        if (key == tms_pkg::KEY_ONE) begin
          song_nxt = tms_pkg::SONG_FIRST;
          top_nxt  = TOP_COUNT;
        end else if (key == tms_pkg::KEY_TWO) begin
          song_nxt = tms_pkg::SONG_SECOND;
          top_nxt  = TOP_COUNT;
        end
      end
      TOP_COUNT: begin
        elapsed_nxt = '0;
        top_nxt     = TOP_WAIT;
        cnt_nxt     = CNT_THREE;
      end
      TOP_PLAY: begin
        if (idx_r < song_notes) begin
          note_nxt = NOTE_START;
          top_nxt  = TOP_WAIT;
        end else begin
          top_nxt = TOP_WELCOME;
        end
      end
      default: ;
    endcase

    unique case (cnt_r)
      CNT_THREE: begin
        led_nxt = led_nxt | tms_pkg::LED_TWO_BIT;
        if (elapsed_nxt > {1'b0, count_step_r}) begin
          led_nxt     = led_nxt & ~tms_pkg::LED_TWO_BIT;
          cnt_nxt     = CNT_TWO;
          elapsed_nxt = '0;
        end
      end
      CNT_TWO: begin
        led_nxt = led_nxt | tms_pkg::LED_ONE_BIT;
        if (elapsed_nxt > {1'b0, count_step_r}) begin
          led_nxt     = led_nxt & ~tms_pkg::LED_ONE_BIT;
          cnt_nxt     = CNT_ONE;
          elapsed_nxt = '0;
        end
      end
      CNT_ONE: begin
        led_nxt = led_nxt | tms_pkg::LED_TWO_BIT;
        if (elapsed_nxt > {1'b0, count_step_r}) begin
          led_nxt     = led_nxt & ~tms_pkg::LED_TWO_BIT;
          cnt_nxt     = CNT_GO;
          elapsed_nxt = '0;
        end
      end
      CNT_GO: begin
        led_nxt = tms_pkg::LED_ONE_BIT | tms_pkg::LED_TWO_BIT;
        if (elapsed_nxt > {1'b0, go_step_r}) begin
          led_nxt = '0;
          cnt_nxt = CNT_DONE;
        end
      end
      CNT_DONE: begin
        cnt_nxt = CNT_IDLE;
        top_nxt = TOP_PLAY;
      end
      default: ;
    endcase

    // The note step sees the phase left by the top step.
    unique case (note_nxt)
      NOTE_START: begin
        if (song_nxt == tms_pkg::SONG_FIRST || song_nxt == tms_pkg::SONG_SECOND) begin
          pitch_nxt   = rom_word.pitch;
          len_nxt     = rom_word.length;
          elapsed_nxt = '0;
          note_nxt    = NOTE_SOUND;
        end
      end
      NOTE_SOUND: begin
        if ({1'b0, elapsed_nxt} > note_limit) begin
          idx_nxt  = idx_nxt + 6'd1;
          top_nxt  = TOP_PLAY;
          note_nxt = NOTE_IDLE;
        end else begin
          sounding = 1'b1;
        end
      end
      default: ;
    endcase

    // Key overrides.
    case (key)
      tms_pkg::KEY_HASH: begin
        top_nxt  = TOP_WELCOME;
        note_nxt = NOTE_IDLE;
        cnt_nxt  = CNT_IDLE;
        sounding = 1'b0;
        led_nxt  = led_nxt | tms_pkg::LED_TWO_BIT;
      end
      tms_pkg::KEY_PAUSE: begin
        top_nxt  = TOP_WAIT;
        cnt_nxt  = CNT_IDLE;
        note_nxt = NOTE_IDLE;
        led_nxt  = (led_nxt & ~tms_pkg::LED_TWO_BIT) | tms_pkg::LED_ONE_BIT;
        sounding = 1'b0;
      end
      tms_pkg::KEY_RESUME: begin
        top_nxt = TOP_PLAY;
        led_nxt = (led_nxt & ~tms_pkg::LED_ONE_BIT) | tms_pkg::LED_TWO_BIT;
      end
      tms_pkg::KEY_THREE: tempo_nxt = tms_pkg::TEMPO_20;
      tms_pkg::KEY_FOUR:  tempo_nxt = tms_pkg::TEMPO_25;
      tms_pkg::KEY_FIVE:  tempo_nxt = tms_pkg::TEMPO_30;
      tms_pkg::KEY_SIX:   tempo_nxt = tms_pkg::TEMPO_35;
      tms_pkg::KEY_SEVEN: tempo_nxt = tms_pkg::TEMPO_40;
      default: ;
    endcase

    // Screen follows the countdown first, then the top phase.
    if (cnt_nxt >= CNT_THREE && cnt_nxt <= CNT_GO) begin
      screen = cnt_nxt + 3'd1;
    end else if (top_nxt == TOP_WELCOME) begin
      screen = tms_pkg::SCR_WELCOME;
    end else if (top_nxt == TOP_LIST) begin
      screen = tms_pkg::SCR_LIST;
    end else begin
      screen = tms_pkg::SCR_BLANK;
    end

    sounding = sounding && (pitch_nxt != '0);
    out_data_nxt.buzzer_enable = sounding;
    out_data_nxt.buzzer_freq   = sounding ? pitch_nxt : '0;
    out_data_nxt.led_one       = led_nxt[0];
    out_data_nxt.led_two       = led_nxt[1];
    out_data_nxt.screen_code   = screen;
    out_data_nxt.note_position = idx_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_step_r <= tms_pkg::COUNT_STEP_RESET;
      go_step_r    <= tms_pkg::GO_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tms_pkg::CFG_COUNT_STEP: count_step_r <= cfg_data;
        tms_pkg::CFG_GO_STEP:    go_step_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= TOP_WELCOME;
      cnt_r     <= CNT_IDLE;
      note_r    <= NOTE_IDLE;
      song_r    <= tms_pkg::SONG_NONE;
      idx_r     <= '0;
      tempo_r   <= tms_pkg::TEMPO_30;
      elapsed_r <= '0;
      pitch_r   <= '0;
      len_r     <= '0;
      led_r     <= '0;
    end else if (in_acc) begin
      top_r     <= top_nxt;
      cnt_r     <= cnt_nxt;
      note_r    <= note_nxt;
      song_r    <= song_nxt;
      idx_r     <= idx_nxt;
      tempo_r   <= tempo_nxt;
      elapsed_r <= elapsed_nxt;
      pitch_r   <= pitch_nxt;
      len_r     <= len_nxt;
      led_r     <= led_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // The buzzer never sounds at a zero pitch, and its frequency reads zero whenever it is silent.
  a_buzzer_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.buzzer_enable == (out_data_r.buzzer_freq != '0)))
    else $error("buzzer enable and frequency disagree");

  // An accepted transaction always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // Countdown screens are shown exactly while the countdown runs.
  a_count_screen: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((out_data_r.screen_code >= tms_pkg::SCR_THREE &&
                 out_data_r.screen_code <= tms_pkg::SCR_GO)
                == (cnt_r >= CNT_THREE && cnt_r <= CNT_GO)))
    else $error("screen code does not match countdown phase");

  // The reported position tracks the note index held in state.
  a_position: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_data_r.note_position == idx_r))
    else $error("note position differs from note index");

endmodule
